>>> design/cbpw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbpw_pkg: shared types and constants of the bitplane writer
// Holds the geometry record, the emit item record and the field codes.
// ----------------------------------------------------------------------------
package cbpw_pkg;

    localparam int ADDR_W   = 21;
    localparam int BYTES_N  = 8;
    localparam int SETTLE_CYCLES = 4;

    // Default size limits handed to the top level
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_PLANES = 8;

    // Operation codes of an input beat
    localparam logic OP_PALETTE = 1'b0;
    localparam logic OP_PIXEL   = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] CFG_INTERLEAVED  = 3'd0;
    localparam logic [2:0] CFG_WORD_ALIGN   = 3'd1;
    localparam logic [2:0] CFG_PAL_12BIT    = 3'd2;
    localparam logic [2:0] CFG_PAL_PLACE    = 3'd3;
    localparam logic [2:0] CFG_IMAGE_WIDTH  = 3'd4;
    localparam logic [2:0] CFG_IMAGE_HEIGHT = 3'd5;
    localparam logic [2:0] CFG_COLOR_COUNT  = 3'd6;

    // Palette placement codes
    localparam logic [1:0] PLACE_NONE   = 2'd0;
    localparam logic [1:0] PLACE_BEFORE = 2'd1;
    localparam logic [1:0] PLACE_AFTER  = 2'd2;

    // Geometry derived from the configuration registers
    typedef struct packed {
        logic [10:0]       width;
        logic [10:0]       height;
        logic [8:0]        colors;
        logic [3:0]        planes;
        logic [8:0]        line_bytes;
        logic [ADDR_W-1:0] plane_step;
        logic [12:0]       line_step;
        logic [10:0]       data_offset;
        logic [ADDR_W-1:0] pal_base;
        logic              pal_12bit;
        logic              pal_on;
        logic              busy;
        logic              load_base;
    } geom_t;

    // One group of byte writes: count bytes per column, one or two columns
    typedef struct packed {
        logic [ADDR_W-1:0]             start;
        logic [ADDR_W-1:0]             step;
        logic [3:0]                    count;
        logic                          two_cols;
        logic [BYTES_N-1:0][7:0]       bytes;
    } item_t;

    // Number of significant bits of an 8-bit value
    function automatic logic [3:0] bit_length(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (v[i]) begin
                n = 4'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

>>> design/cbpw_geom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbpw_geom: configuration registers and derived image geometry
// Clamps sizes, derives plane count, line and plane steps and offsets over
// three registered stages, and holds off input until they settle.
// ----------------------------------------------------------------------------
module cbpw_geom #(
    parameter int MAX_WIDTH  = cbpw_pkg::MAX_WIDTH,
    parameter int MAX_HEIGHT = cbpw_pkg::MAX_HEIGHT,
    parameter int MAX_PLANES = cbpw_pkg::MAX_PLANES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [2:0]        cfg_index,
    input  logic [10:0]       cfg_data,
    output cbpw_pkg::geom_t   geom,
    output logic              restart
);

    logic        interleaved_reg, word_align_reg, pal_12bit_reg;
    logic [1:0]  placement_reg;
    logic [10:0] width_reg, height_reg;
    logic [8:0]  colors_reg;
    logic [2:0]  settle_reg, settle_next;

    logic [10:0] w_a, h_a;
    logic [8:0]  c_a;
    logic [3:0]  bl_a, planes_a;
    logic [11:0] padded_a;
    logic [8:0]  lb_a;

    logic [10:0] w_a_reg, h_a_reg;
    logic [8:0]  c_a_reg;
    logic [3:0]  planes_a_reg;
    logic [8:0]  lb_a_reg;

    logic [19:0] lbh_b_reg;
    logic [12:0] line_step_b_reg;
    logic [10:0] data_off_b_reg;

    logic [cbpw_pkg::ADDR_W-1:0] pstep_c_reg, pal_base_c_reg;
    logic [23:0] data_size_c;

    assign restart = cfg_write && (cfg_index <= cbpw_pkg::CFG_COLOR_COUNT);

    // Store register writes
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            interleaved_reg <= 1'b1;
            word_align_reg  <= 1'b1;
            pal_12bit_reg   <= 1'b0;
            placement_reg   <= cbpw_pkg::PLACE_AFTER;
            width_reg       <= 11'd320;
            height_reg      <= 11'd256;
            colors_reg      <= 9'd32;
        end else if (cfg_write) begin
            unique case (cfg_index)
                cbpw_pkg::CFG_INTERLEAVED:  interleaved_reg <= cfg_data[0];
                cbpw_pkg::CFG_WORD_ALIGN:   word_align_reg  <= cfg_data[0];
                cbpw_pkg::CFG_PAL_12BIT:    pal_12bit_reg   <= cfg_data[0];
                cbpw_pkg::CFG_PAL_PLACE:    placement_reg   <= cfg_data[1:0];
                cbpw_pkg::CFG_IMAGE_WIDTH:  width_reg       <= cfg_data;
                cbpw_pkg::CFG_IMAGE_HEIGHT: height_reg      <= cfg_data;
                cbpw_pkg::CFG_COLOR_COUNT:  colors_reg      <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Clamp sizes and find plane count and padded line length
    always_comb begin
        if (width_reg == 11'd0) begin
            w_a = 11'd1;
        end else if (32'(width_reg) > MAX_WIDTH) begin
            w_a = 11'(MAX_WIDTH);
        end else begin
            w_a = width_reg;
        end
        if (height_reg == 11'd0) begin
            h_a = 11'd1;
        end else if (32'(height_reg) > MAX_HEIGHT) begin
            h_a = 11'(MAX_HEIGHT);
        end else begin
            h_a = height_reg;
        end
        if (colors_reg == 9'd0) begin
            c_a = 9'd1;
        end else if (colors_reg > 9'd256) begin
            c_a = 9'd256;
        end else begin
            c_a = colors_reg;
        end
        bl_a = cbpw_pkg::bit_length(8'(c_a - 9'd1));
        planes_a = (32'(bl_a) > MAX_PLANES) ? 4'(MAX_PLANES) : bl_a;
        padded_a = ({1'b0, w_a} + (word_align_reg ? 12'd15 : 12'd7))
                   & (word_align_reg ? 12'hff0 : 12'hff8);
        lb_a = padded_a[11:3];
    end

    assign data_size_c = 24'(lbh_b_reg) * 24'(planes_a_reg);

    // Derive steps and offsets over three stages
    always_ff @(posedge clk) begin
        w_a_reg      <= w_a;
        h_a_reg      <= h_a;
        c_a_reg      <= c_a;
        planes_a_reg <= planes_a;
        lb_a_reg     <= lb_a;

        lbh_b_reg       <= 20'(lb_a_reg) * 20'(h_a_reg);
        line_step_b_reg <= interleaved_reg ? 13'(lb_a_reg) * 13'(planes_a_reg)
                                           : 13'(lb_a_reg);
        if (placement_reg == cbpw_pkg::PLACE_BEFORE) begin
            data_off_b_reg <= pal_12bit_reg ? {1'b0, c_a_reg, 1'b0} : {c_a_reg, 2'b00};
        end else begin
            data_off_b_reg <= 11'd0;
        end

        pstep_c_reg    <= interleaved_reg ? cbpw_pkg::ADDR_W'(lb_a_reg)
                                          : cbpw_pkg::ADDR_W'(lbh_b_reg);
        pal_base_c_reg <= (placement_reg == cbpw_pkg::PLACE_AFTER)
                          ? data_size_c[cbpw_pkg::ADDR_W-1:0] : '0;
    end

    // Count down while derived values settle after reset or a write
    always_comb begin
        if (restart) begin
            settle_next = 3'(cbpw_pkg::SETTLE_CYCLES);
        end else if (settle_reg != 3'd0) begin
            settle_next = settle_reg - 3'd1;
        end else begin
            settle_next = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            settle_reg <= 3'(cbpw_pkg::SETTLE_CYCLES);
        end else begin
            settle_reg <= settle_next;
        end
    end

    always_comb begin
        geom.width       = w_a_reg;
        geom.height      = h_a_reg;
        geom.colors      = c_a_reg;
        geom.planes      = planes_a_reg;
        geom.line_bytes  = lb_a_reg;
        geom.plane_step  = pstep_c_reg;
        geom.line_step   = line_step_b_reg;
        geom.data_offset = data_off_b_reg;
        geom.pal_base    = pal_base_c_reg;
        geom.pal_12bit   = pal_12bit_reg;
        geom.pal_on      = (placement_reg == cbpw_pkg::PLACE_BEFORE)
                           || (placement_reg == cbpw_pkg::PLACE_AFTER);
        geom.busy        = (settle_reg != 3'd0);
        geom.load_base   = (settle_reg == 3'd1);
    end

endmodule

>>> design/cbpw_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbpw_emit: byte write sequencer
// Holds one item and sends its byte writes, one beat per cycle while the output is
// not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module cbpw_emit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  cbpw_pkg::item_t             item,
    output logic                        free,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [cbpw_pkg::ADDR_W-1:0] address,
    output logic [7:0]                  byte_value,
    output logic                        last
);

    cbpw_pkg::item_t             item_reg;
    logic                        item_valid_reg;
    logic [2:0]                  plane_cnt_reg;
    logic                        col_cnt_reg;
    logic [cbpw_pkg::ADDR_W-1:0] addr_reg;
    logic                        out_valid_reg;
    logic [cbpw_pkg::ADDR_W-1:0] address_reg;
    logic [7:0]                  byte_reg;
    logic                        last_reg;

    logic out_ok, beat, plane_end, last_beat;

    assign out_ok    = !out_valid_reg || !out_stall;
    assign beat      = item_valid_reg && out_ok;
    assign plane_end = (plane_cnt_reg == 3'(item_reg.count - 4'd1));
    assign last_beat = plane_end && (col_cnt_reg == item_reg.two_cols);
    assign free      = !item_valid_reg || (beat && last_beat);

    // Track item and output occupancy
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (load) begin
                item_valid_reg <= 1'b1;
            end else if (beat && last_beat) begin
                item_valid_reg <= 1'b0;
            end
            if (beat) begin
                out_valid_reg <= 1'b1;
            end else if (!out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Advance plane and column counters and the write address
    always_ff @(posedge clk) begin
        if (load) begin
            item_reg      <= item;
            plane_cnt_reg <= 3'd0;
            col_cnt_reg   <= 1'b0;
            addr_reg      <= item.start;
        end else if (beat && !last_beat) begin
            if (plane_end) begin
                plane_cnt_reg <= 3'd0;
                col_cnt_reg   <= 1'b1;
                addr_reg      <= item_reg.start + cbpw_pkg::ADDR_W'(1);
            end else begin
                plane_cnt_reg <= plane_cnt_reg + 3'd1;
                addr_reg      <= addr_reg + item_reg.step;
            end
        end
        if (beat) begin
            address_reg <= addr_reg;
            byte_reg    <= col_cnt_reg ? 8'd0 : item_reg.bytes[plane_cnt_reg];
            last_reg    <= last_beat;
        end
    end

    assign out_valid  = out_valid_reg;
    assign address    = address_reg;
    assign byte_value = byte_reg;
    assign last       = last_reg;

endmodule

>>> design/chunky_to_planar_bitplane_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunky_to_planar_bitplane_writer: palette and pixel stream to planar bytes
// Gathers pixel bits per plane and issues addressed byte writes of the
// bitplane image and its palette.
// ----------------------------------------------------------------------------
// The first byte write of an item passes the item register, then the output register.
// Throughput: one input beat per cycle while in_stall is low; an item causing n
// byte writes holds the byte sequencer until its last write is sent, stalling input.
// Reset and every write to register indexes 0 to 6 stall the input while the
// geometry settles; reset loads default registers and restarts the frame.
// ----------------------------------------------------------------------------
module chunky_to_planar_bitplane_writer #(
    parameter int MAX_WIDTH  = cbpw_pkg::MAX_WIDTH,
    parameter int MAX_HEIGHT = cbpw_pkg::MAX_HEIGHT,
    parameter int MAX_PLANES = cbpw_pkg::MAX_PLANES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [2:0]                  cfg_index,
    input  logic [10:0]                 cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        operation,
    input  logic [7:0]                  pixel_index,
    input  logic [7:0]                  palette_slot,
    input  logic [7:0]                  red,
    input  logic [7:0]                  green,
    input  logic [7:0]                  blue,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [cbpw_pkg::ADDR_W-1:0] address,
    output logic [7:0]                  byte_value,
    output logic                        last
);

    cbpw_pkg::geom_t geom;
    cbpw_pkg::item_t item;
    logic            restart, free, accept, load;

    logic [10:0]                  column_reg, column_next;
    logic [10:0]                  row_reg, row_next;
    logic [cbpw_pkg::ADDR_W-1:0]  row_base_reg, row_base_next;
    logic [MAX_PLANES-1:0][7:0]   plane_bytes_reg, plane_bytes_next;
    logic [MAX_PLANES-1:0][7:0]   new_bytes;

    logic [11:0] col_inc, row_inc;
    logic        row_end, dump, pad, pix_emit, pal_hit;
    logic [7:0]  bitmask, bx;

    cbpw_geom #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_PLANES (MAX_PLANES)
    ) u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom),
        .restart   (restart)
    );

    cbpw_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .item       (item),
        .free       (free),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .address    (address),
        .byte_value (byte_value),
        .last       (last)
    );

    assign in_stall = geom.busy || !free;
    assign accept   = in_valid && !in_stall;

    // Set this pixel's bits and decide which bytes leave
    always_comb begin
        col_inc = {1'b0, column_reg} + 12'd1;
        row_inc = {1'b0, row_reg} + 12'd1;
        row_end = (col_inc >= {1'b0, geom.width});
        bitmask = 8'h80 >> column_reg[2:0];
        bx      = column_reg[10:3];
        dump    = (column_reg[2:0] == 3'd7) || row_end;
        pad     = row_end && (({1'b0, bx} + 9'd1) < geom.line_bytes);
        for (int i = 0; i < MAX_PLANES; i++) begin
            new_bytes[i] = plane_bytes_reg[i];
            if (pixel_index[i] && (i < 32'(geom.planes))) begin
                new_bytes[i] = plane_bytes_reg[i] | bitmask;
            end
        end
        pix_emit = dump && (geom.planes != 4'd0);
        pal_hit  = geom.pal_on && ({1'b0, palette_slot} < geom.colors);
    end

    // Build the byte group for the sequencer
    always_comb begin
        item = '0;
        if (operation == cbpw_pkg::OP_PIXEL) begin
            item.start    = row_base_reg + cbpw_pkg::ADDR_W'(bx);
            item.step     = geom.plane_step;
            item.count    = geom.planes;
            item.two_cols = pad;
            for (int j = 0; j < cbpw_pkg::BYTES_N; j++) begin
                if (j < MAX_PLANES) begin
                    item.bytes[j] = new_bytes[j];
                end
            end
        end else begin
            item.step     = cbpw_pkg::ADDR_W'(1);
            item.two_cols = 1'b0;
            if (geom.pal_12bit) begin
                item.start    = geom.pal_base
                                + cbpw_pkg::ADDR_W'({palette_slot, 1'b0});
                item.count    = 4'd2;
                item.bytes[0] = {4'd0, red[7:4]};
                item.bytes[1] = (green & 8'hf0) | {4'd0, blue[7:4]};
            end else begin
                item.start    = geom.pal_base
                                + cbpw_pkg::ADDR_W'({palette_slot, 2'b00});
                item.count    = 4'd4;
                item.bytes[0] = 8'd0;
                item.bytes[1] = red;
                item.bytes[2] = green;
                item.bytes[3] = blue;
            end
        end
    end

    assign load = accept && ((operation == cbpw_pkg::OP_PIXEL) ? pix_emit : pal_hit);

    // Advance column, row and row base on each pixel beat; restart and settle reset them
    always_comb begin
        column_next      = column_reg;
        row_next         = row_reg;
        row_base_next    = row_base_reg;
        plane_bytes_next = plane_bytes_reg;
        if (restart) begin
            column_next      = 11'd0;
            row_next         = 11'd0;
            plane_bytes_next = '0;
        end else if (accept && (operation == cbpw_pkg::OP_PIXEL)) begin
            plane_bytes_next = dump ? '0 : new_bytes;
            if (row_end) begin
                column_next = 11'd0;
                if (row_inc >= {1'b0, geom.height}) begin
                    row_next      = 11'd0;
                    row_base_next = cbpw_pkg::ADDR_W'(geom.data_offset);
                end else begin
                    row_next      = row_inc[10:0];
                    row_base_next = row_base_reg + cbpw_pkg::ADDR_W'(geom.line_step);
                end
            end else begin
                column_next = col_inc[10:0];
            end
        end
        if (geom.load_base) begin
            row_base_next = cbpw_pkg::ADDR_W'(geom.data_offset);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            column_reg      <= 11'd0;
            row_reg         <= 11'd0;
            row_base_reg    <= '0;
            plane_bytes_reg <= '0;
        end else begin
            column_reg      <= column_next;
            row_reg         <= row_next;
            row_base_reg    <= row_base_next;
            plane_bytes_reg <= plane_bytes_next;
        end
    end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the chunky-to-planar bitplane writer
// Drives palette and pixel beats under random gaps and back-pressure. An
// internal planar byte model predicts each addressed byte write. A checker
// compares every output beat against the oldest predicted write.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned MAX_W        = cbpw_pkg::MAX_WIDTH;
    localparam int unsigned MAX_H        = cbpw_pkg::MAX_HEIGHT;
    localparam int unsigned MAX_COLORS   = 256;
    localparam int unsigned ADDR_MASK    = 32'h1F_FFFF;
    localparam int unsigned DRAIN_CYCLES = cbpw_pkg::SETTLE_CYCLES + 6;
    localparam int unsigned HOLD_CYCLES  = 250;
    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam logic [2:0]  CFG_UNUSED     = 3'd7;
    localparam logic [1:0]  PLACE_RESERVED = 2'd3;

    // Register image kept by the model
    typedef struct {
        logic        interleaved;
        logic        word_align;
        logic        pal_12bit;
        logic [1:0]  placement;
        logic [10:0] width;
        logic [10:0] height;
        logic [8:0]  colors;
    } settings_t;

    // One predicted byte write
    typedef struct packed {
        logic [cbpw_pkg::ADDR_W-1:0] addr;
        logic [7:0]                  value;
        logic                        last;
    } byte_write_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_write = 1'b0;
    logic [2:0]                  cfg_index = 3'd0;
    logic [10:0]                 cfg_data = 11'd0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic                        operation = cbpw_pkg::OP_PIXEL;
    logic [7:0]                  pixel_index = 8'd0;
    logic [7:0]                  palette_slot = 8'd0;
    logic [7:0]                  red = 8'd0;
    logic [7:0]                  green = 8'd0;
    logic [7:0]                  blue = 8'd0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [cbpw_pkg::ADDR_W-1:0] address;
    logic [7:0]                  byte_value;
    logic                        last;

    chunky_to_planar_bitplane_writer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .pixel_index  (pixel_index),
        .palette_slot (palette_slot),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .address      (address),
        .byte_value   (byte_value),
        .last         (last)
    );

    // Model state
    settings_t     cur;
    int unsigned   geo_width, geo_height, geo_colors, geo_planes;
    int unsigned   geo_line, geo_pstep, geo_lstep, geo_entry, geo_doff;
    int unsigned   pix_col, pix_row, row_base;
    logic [7:0]    plane_acc [8];
    byte_write_t   pending_writes [$];
    int unsigned   error_count = 0;
    int unsigned   cycle_count = 0;
    bit            sender_bursty = 1'b0;
    bit            hold_req = 1'b0;
    bit            hold_active = 1'b0;

    // Clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // Random gap length: mostly zero or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Recompute the planar geometry from the register image
    function automatic void derive_geometry();
        int unsigned c;
        geo_width  = (cur.width < 1) ? 1 : (cur.width > MAX_W) ? MAX_W : cur.width;
        geo_height = (cur.height < 1) ? 1 : (cur.height > MAX_H) ? MAX_H : cur.height;
        geo_colors = (cur.colors < 1) ? 1 : (cur.colors > MAX_COLORS) ? MAX_COLORS
                                                                      : cur.colors;
        c = geo_colors - 1;
        geo_planes = 0;
        while (c > 0)
        begin
            geo_planes++;
            c >>= 1;
        end
        if (cur.word_align)
            geo_line = ((geo_width + 15) & ~32'd15) >> 3;
        else
            geo_line = ((geo_width + 7) & ~32'd7) >> 3;
        geo_pstep = cur.interleaved ? geo_line : geo_line * geo_height;
        geo_lstep = cur.interleaved ? geo_line * geo_planes : geo_line;
        geo_entry = cur.pal_12bit ? 2 : 4;
        geo_doff  = (cur.placement == cbpw_pkg::PLACE_BEFORE) ? geo_colors * geo_entry : 0;
    endfunction

    // Restart the frame: clear position and gathered bits
    function automatic void restart_frame();
        derive_geometry();
        pix_col  = 0;
        pix_row  = 0;
        row_base = geo_doff & ADDR_MASK;
        for (int p = 0; p < 8; p++)
            plane_acc[p] = 8'd0;
    endfunction

    function automatic void add_write(int unsigned a, logic [7:0] v);
        byte_write_t w;
        w.addr  = a[cbpw_pkg::ADDR_W-1:0];
        w.value = v;
        w.last  = 1'b0;
        pending_writes.push_back(w);
    endfunction

    // Predict the byte writes caused by one accepted input beat
    function automatic void plan_byte_writes(logic op, logic [7:0] pix, logic [7:0] slot,
                                             logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int unsigned first, a, bx;
        logic [7:0]  mask;
        bit          row_end;
        byte_write_t w;
        first = pending_writes.size();
        if (op == cbpw_pkg::OP_PALETTE)
        begin
            if ((cur.placement == cbpw_pkg::PLACE_BEFORE
                 || cur.placement == cbpw_pkg::PLACE_AFTER)
                && slot < geo_colors)
            begin
                a = (cur.placement == cbpw_pkg::PLACE_AFTER)
                    ? geo_line * geo_height * geo_planes : 0;
                a += slot * geo_entry;
                if (cur.pal_12bit)
                begin
                    add_write(a, {4'd0, r[7:4]});
                    add_write(a + 1, {g[7:4], b[7:4]});
                end
                else
                begin
                    add_write(a, 8'd0);
                    add_write(a + 1, r);
                    add_write(a + 2, g);
                    add_write(a + 3, b);
                end
            end
        end
        else
        begin
            mask    = 8'h80 >> (pix_col & 7);
            row_end = (pix_col + 1 >= geo_width);
            for (int p = 0; p < geo_planes; p++)
                if (pix[p])
                    plane_acc[p] = plane_acc[p] | mask;
            // Flush a full byte column, or the partial one at row end
            if ((pix_col & 7) == 7 || row_end)
            begin
                bx = pix_col >> 3;
                for (int p = 0; p < geo_planes; p++)
                begin
                    add_write(row_base + p * geo_pstep + bx, plane_acc[p]);
                    plane_acc[p] = 8'd0;
                end
                // Zero padding for the rest of the line
                if (row_end)
                    for (int unsigned x = bx + 1; x < geo_line; x++)
                        for (int p = 0; p < geo_planes; p++)
                            add_write(row_base + p * geo_pstep + x, 8'd0);
            end
            if (row_end)
            begin
                pix_col = 0;
                pix_row++;
                if (pix_row >= geo_height)
                    pix_row = 0;
                row_base = (geo_doff + pix_row * geo_lstep) & ADDR_MASK;
            end
            else
            begin
                pix_col++;
            end
        end
        // Mark the final write of this beat
        if (pending_writes.size() > first)
        begin
            w = pending_writes[pending_writes.size() - 1];
            pending_writes.pop_back();
            w.last = 1'b1;
            pending_writes.push_back(w);
        end
    endfunction

    // Predict on every accepted input beat
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            plan_byte_writes(operation, pixel_index, palette_slot, red, green, blue);
    end

    // Compare every accepted output beat with the oldest prediction
    always @(posedge clk)
    begin : check_writes
        byte_write_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_writes.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected write: expected none, got addr %h value %h last %b",
                         $time, address, byte_value, last);
            end
            else
            begin
                w = pending_writes.pop_front();
                if (address !== w.addr || byte_value !== w.value || last !== w.last)
                begin
                    error_count++;
                    $display("%0t: mismatch: expected addr %h value %h last %b, %s %h %h %b",
                             $time, w.addr, w.value, w.last, "got addr value last",
                             address, byte_value, last);
                end
            end
        end
    end

    // Receiver: random stall runs, plus one long hold-off on request
    initial
    begin : receiver
        int unsigned n;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req    = 1'b0;
                hold_active = 1'b1;
                out_stall <= 1'b1;
                for (int unsigned i = 0; i < HOLD_CYCLES; i++)
                    @(posedge clk);
                hold_active = 1'b0;
            end
            n = pick_gap();
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            if ($urandom_range(0, 9) == 0)
                repeat (40) @(posedge clk);
            else
                repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // Watchdog
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // Offer one beat after an optional gap and hold it until accepted
    task automatic send_beat(input logic op, input logic [7:0] pix, input logic [7:0] slot,
                             input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input int unsigned gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        pixel_index  <= pix;
        palette_slot <= slot;
        red          <= r;
        green        <= g;
        blue         <= b;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_pixel(input logic [7:0] pix, input int unsigned gap);
        send_beat(cbpw_pkg::OP_PIXEL, pix, 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), gap);
    endtask

    task automatic send_entry(input logic [7:0] slot, input logic [7:0] r,
                              input logic [7:0] g, input logic [7:0] b,
                              input int unsigned gap);
        send_beat(cbpw_pkg::OP_PALETTE, 8'($urandom), slot, r, g, b, gap);
    endtask

    // Drop valid and wait until every predicted write has come out
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write one register; the caller lowers the write enable afterwards
    task automatic reg_write(input logic [2:0] idx, input logic [10:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            cbpw_pkg::CFG_INTERLEAVED:  cur.interleaved = val[0];
            cbpw_pkg::CFG_WORD_ALIGN:   cur.word_align  = val[0];
            cbpw_pkg::CFG_PAL_12BIT:    cur.pal_12bit   = val[0];
            cbpw_pkg::CFG_PAL_PLACE:    cur.placement   = val[1:0];
            cbpw_pkg::CFG_IMAGE_WIDTH:  cur.width       = val;
            cbpw_pkg::CFG_IMAGE_HEIGHT: cur.height      = val;
            cbpw_pkg::CFG_COLOR_COUNT:  cur.colors      = val[8:0];
            default: ;
        endcase
        if (idx <= cbpw_pkg::CFG_COLOR_COUNT)
            restart_frame();
        @(posedge clk);
    endtask

    // Load a full register set while the block is idle
    task automatic apply_settings(input settings_t s);
        wait_idle();
        reg_write(cbpw_pkg::CFG_INTERLEAVED, {10'd0, s.interleaved});
        reg_write(cbpw_pkg::CFG_WORD_ALIGN, {10'd0, s.word_align});
        reg_write(cbpw_pkg::CFG_PAL_12BIT, {10'd0, s.pal_12bit});
        reg_write(cbpw_pkg::CFG_PAL_PLACE, {9'd0, s.placement});
        reg_write(cbpw_pkg::CFG_IMAGE_WIDTH, s.width);
        reg_write(cbpw_pkg::CFG_IMAGE_HEIGHT, s.height);
        reg_write(cbpw_pkg::CFG_COLOR_COUNT, {2'd0, s.colors});
        cfg_write <= 1'b0;
    endtask

    function automatic settings_t make_settings(logic inter, logic align, logic p12,
                                                logic [1:0] place, logic [10:0] w,
                                                logic [10:0] h, logic [8:0] c);
        settings_t s;
        s.interleaved = inter;
        s.word_align  = align;
        s.pal_12bit   = p12;
        s.placement   = place;
        s.width       = w;
        s.height      = h;
        s.colors      = c;
        return s;
    endfunction

    function automatic settings_t random_settings();
        settings_t   s;
        int unsigned r;
        int unsigned color_picks [10] = '{1, 2, 3, 4, 16, 17, 128, 255, 256, 0};
        s.interleaved = 1'($urandom_range(0, 1));
        s.word_align  = 1'($urandom_range(0, 1));
        s.pal_12bit   = 1'($urandom_range(0, 1));
        s.placement   = 2'($urandom_range(0, 3));
        r = $urandom_range(0, 99);
        if (r < 70)
            s.width = 11'($urandom_range(1, 24));
        else if (r < 85)
            s.width = 11'($urandom_range(25, 80));
        else if (r < 92)
            s.width = 11'(MAX_W);
        else if (r < 96)
            s.width = 11'd0;
        else
            s.width = 11'($urandom_range(MAX_W + 1, 2047));
        if ($urandom_range(0, 9) < 7)
            s.height = 11'($urandom_range(1, 4));
        else
            s.height = 11'($urandom_range(0, 2047));
        if ($urandom_range(0, 2) == 0)
            s.colors = 9'($urandom_range(0, 511));
        else
            s.colors = 9'(color_picks[$urandom_range(0, 9)]);
        return s;
    endfunction

    // Reset register set: 320x256, 32 colors, palette after the data
    task automatic test_default_frame();
        send_entry(8'd0, 8'hFF, 8'h00, 8'hFF, 0);
        send_entry(8'd31, 8'h00, 8'hFF, 8'h00, pick_gap());
        send_entry(8'd32, 8'h12, 8'h34, 8'h56, 0);
        send_entry(8'd255, 8'hAA, 8'h55, 8'hAA, 0);
        send_pixel(8'hFF, 0);
        send_pixel(8'h00, 0);
        send_pixel(8'h15, pick_gap());
        send_pixel(8'h0A, 0);
        send_pixel(8'hE0, 0);
        send_pixel(8'h1F, pick_gap());
        send_pixel(8'h01, 0);
        send_pixel(8'h10, 0);
    endtask

    // Clamped sizes, both ends; palette first; reserved placement
    task automatic test_clamped_sizes();
        apply_settings(make_settings(1'b0, 1'b0, 1'b1, cbpw_pkg::PLACE_BEFORE, 11'd0,
                                     11'd1, 9'd256));
        send_entry(8'd255, 8'hAB, 8'hCD, 8'hEF, 0);
        send_pixel(8'hFF, 0);
        send_pixel(8'h5A, pick_gap());
        apply_settings(make_settings(1'b0, 1'b0, 1'b1, PLACE_RESERVED, 11'd0, 11'd1,
                                     9'd256));
        send_entry(8'd3, 8'h11, 8'h22, 8'h33, 0);
        send_pixel(8'hA5, 0);
        apply_settings(make_settings(1'b1, 1'b1, 1'b0, cbpw_pkg::PLACE_AFTER, 11'd2047,
                                     11'd2047, 9'd511));
        send_entry(8'd0, 8'h80, 8'h7F, 8'h01, 0);
        send_pixel(8'h80, 0);
        send_pixel(8'h7F, 0);
    endtask

    // One color: no planes, pixels give nothing; unused register index
    task automatic test_single_color();
        apply_settings(make_settings(1'b1, 1'b0, 1'b1, cbpw_pkg::PLACE_AFTER, 11'd5,
                                     11'd2, 9'd0));
        send_pixel(8'hFF, 0);
        send_pixel(8'h00, 0);
        send_entry(8'd0, 8'hF0, 8'h0F, 8'hF0, 0);
        send_entry(8'd1, 8'h0F, 8'hF0, 8'h0F, 0);
        wait_idle();
        reg_write(CFG_UNUSED, 11'($urandom));
        cfg_write <= 1'b0;
        send_pixel(8'h3C, 0);
    endtask

    // Two colors, short row padded to a word; upper index bits ignored
    task automatic test_row_padding();
        apply_settings(make_settings(1'b0, 1'b1, 1'b0, cbpw_pkg::PLACE_BEFORE, 11'd3,
                                     11'd2, 9'd2));
        send_pixel(8'hFE, 0);
        send_pixel(8'h01, pick_gap());
        send_pixel(8'hFF, 0);
        send_entry(8'd1, 8'h00, 8'h00, 8'h00, 0);
        send_entry(8'd2, 8'hFF, 8'hFF, 8'hFF, 0);
    endtask

    // Hold the receiver off while pixels keep coming, so the input stalls
    task automatic test_back_pressure();
        apply_settings(make_settings(1'b1, 1'b1, 1'b0, cbpw_pkg::PLACE_NONE, 11'd2,
                                     11'd3, 9'd256));
        hold_req = 1'b1;
        wait (hold_active);
        @(posedge clk);
        for (int i = 0; i < 24; i++)
            send_pixel(8'($urandom), 0);
    endtask

    // Random register sets, each followed by a run of mixed beats
    task automatic test_random_frames();
        int unsigned slot_max;
        for (int phase = 0; phase < 4; phase++)
        begin
            apply_settings(random_settings());
            sender_bursty = ($urandom_range(0, 3) == 0);
            slot_max = geo_colors - 1;
            for (int i = 0; i < 12; i++)
            begin
                if ($urandom_range(0, 3) != 0)
                    send_pixel(8'($urandom), sender_bursty ? 0 : pick_gap());
                else if ($urandom_range(0, 4) != 0)
                    send_entry(8'($urandom_range(0, slot_max)), 8'($urandom), 8'($urandom),
                               8'($urandom), sender_bursty ? 0 : pick_gap());
                else
                    send_entry(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                               sender_bursty ? 0 : pick_gap());
            end
        end
    endtask

    // Main sequence
    initial
    begin
        cur = make_settings(1'b1, 1'b1, 1'b0, cbpw_pkg::PLACE_AFTER, 11'd320, 11'd256,
                            9'd32);
        restart_frame();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_frame();
        test_clamped_sizes();
        test_single_color();
        test_row_padding();
        test_back_pressure();
        test_random_frames();
        wait_idle();
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
